FILE: rtl/byte_vm_execute_unit_macros.svh
// Assertion macros for the byte VM execute unit.
// Assertions compile away when SYNTH is defined.
`ifndef BYTE_VM_EXECUTE_UNIT_MACROS_SVH
`define BYTE_VM_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTH

`define BVM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bvm assertion failed");

`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bvm assertion failed");

`else

`define BVM_ASSERT_SAME(label, clk, rst, ante, cons)

`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/bvm_pkg.sv
// Shared types and constants of the byte VM execute unit.
// No dependencies.
`default_nettype none

package bvm_pkg;

   localparam int REG_COUNT = 256;
   localparam int MEM_BYTES = 256;
   localparam int REG_WIDTH = 32;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int MEM_IDX_W = $clog2(MEM_BYTES);

   localparam logic [7:0] OP_HALT  = 8'h00;
   localparam logic [7:0] OP_LOAD  = 8'h10;
   localparam logic [7:0] OP_STORE = 8'h20;
   localparam logic [7:0] OP_MOVE  = 8'h30;
   localparam logic [7:0] OP_PUTI  = 8'h40;
   localparam logic [7:0] OP_ADD   = 8'h50;
   localparam logic [7:0] OP_SUB   = 8'h60;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_HALT    = 2'd1,
      ST_IGNORED = 2'd2,
      ST_ILLEGAL = 2'd3
   } bvm_status_type;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] addr;
      logic [REG_WIDTH-1:0] data;
   } bvm_wr_type;

endpackage

`default_nettype wire

FILE: rtl/bvm_regfile.sv
// Register file: two registered read ports, one write port, per-entry valid
// bits for reset-to-zero, and same-edge write forwarding. Uses bvm_pkg.
`default_nettype none

module bvm_regfile
   import bvm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [REG_IDX_W-1:0] rd_addr_a,
   input  wire logic [REG_IDX_W-1:0] rd_addr_b,
   input  wire bvm_wr_type           wr,
   output logic      [REG_WIDTH-1:0] rd_data_a,
   output logic      [REG_WIDTH-1:0] rd_data_b
);

   logic [REG_WIDTH-1:0] regs [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_WIDTH-1:0] rd_a_ff;
   logic [REG_WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   // read-before-write array; a write on the same edge is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == rd_addr_a) begin
            rd_a_ff <= wr.data;
         end else begin
            rd_a_ff <= vld_ff[rd_addr_a] ? regs[rd_addr_a] : '0;
         end
         if (wr.en && wr.addr == rd_addr_b) begin
            rd_b_ff <= wr.data;
         end else begin
            rd_b_ff <= vld_ff[rd_addr_b] ? regs[rd_addr_b] : '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/byte_vm_execute_unit.sv
// Byte VM execute unit: top level with data memory and execute stage.
// Depends on bvm_pkg, bvm_regfile and byte_vm_execute_unit_macros.svh.
//
// Usage:
//   req channel carries one four-byte instruction per word; rsp channel
//   returns exactly one status word per instruction, in order.
//   An instruction accepted at one edge reads the register file (two ports)
//   and the data memory (one port) at that edge; the next cycle it executes,
//   then writes back and loads the output register once that register is
//   empty or rsp_tready is high. Throughput is one word per cycle while
//   rsp_tready is high, including dependent instructions: a write-back on the
//   edge of a read is forwarded. When rsp_tready is low a full output
//   register holds its word and the execute stage holds its instruction;
//   req_tready drops only when both are full. Reset clears all registers,
//   memory and the halt flag through per-entry valid bits; no clearing pass
//   is needed. After a halt every word is answered as ignored until reset.
`default_nettype none
`include "byte_vm_execute_unit_macros.svh"

module byte_vm_execute_unit
   import bvm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // mode, operand_one, operand_two, operand_three
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], reg_written, reg_index[7:0], reg_value[31:0],
   // mem_written, mem_addr[7:0], mem_byte[7:0], 4 zero bits
   output logic      [63:0] rsp_tdata
);

   logic [7:0] req_mode, req_op1, req_op2, req_op3;
   logic       req_acc;

   logic       s1_vld_ff, s1_vld_in;
   logic       s1_adv;
   logic [7:0] s1_mode_ff, s1_op1_ff, s1_op2_ff;

   logic       out_vld_ff, out_vld_in;
   logic [63:0] out_data_ff;

   logic       halted_ff;

   logic [REG_WIDTH-1:0] src_b, src_c;
   bvm_wr_type           rf_wr;

   logic [7:0]           dmem [MEM_BYTES];
   logic [MEM_BYTES-1:0] mem_vld_ff;
   logic [7:0]           mem_rd_ff;

   bvm_status_type       ex_status;
   logic                 ex_wr_reg, ex_wr_mem, ex_halt;
   logic [REG_WIDTH-1:0] ex_value;
   logic [7:0]           ex_byte;
   logic [MEM_IDX_W-1:0] ex_maddr;
   logic [63:0]          ex_word;

   assign req_mode = req_tdata[7:0];
   assign req_op1  = req_tdata[15:8];
   assign req_op2  = req_tdata[23:16];
   assign req_op3  = req_tdata[31:24];

   assign s1_adv     = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign s1_vld_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
   assign out_vld_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (s1_adv && ex_halt) begin
            halted_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_mode_ff <= req_mode;
         s1_op1_ff  <= req_op1;
         s1_op2_ff  <= req_op2;
      end
      if (s1_adv) begin
         out_data_ff <= ex_word;
      end
   end

   bvm_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_acc),
      .rd_addr_a (req_op2[REG_IDX_W-1:0]),
      .rd_addr_b (req_op3[REG_IDX_W-1:0]),
      .wr        (rf_wr),
      .rd_data_a (src_b),
      .rd_data_b (src_c)
   );

   // data memory
   always_ff @(posedge clock) begin
      if (s1_adv && ex_wr_mem) begin
         dmem[ex_maddr] <= ex_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (s1_adv && ex_wr_mem) begin
         mem_vld_ff[ex_maddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (s1_adv && ex_wr_mem && ex_maddr == req_op2[MEM_IDX_W-1:0]) begin
            mem_rd_ff <= ex_byte;
         end else if (mem_vld_ff[req_op2[MEM_IDX_W-1:0]]) begin
            mem_rd_ff <= dmem[req_op2[MEM_IDX_W-1:0]];
         end else begin
            mem_rd_ff <= '0;
         end
      end
   end

   // execute
   always_comb begin
      ex_status = ST_DONE;
      ex_wr_reg = 1'b0;
      ex_wr_mem = 1'b0;
      ex_halt   = 1'b0;
      ex_value  = '0;
      ex_byte   = '0;
      ex_maddr  = s1_op1_ff[MEM_IDX_W-1:0];
      if (halted_ff) begin
         ex_status = ST_IGNORED;
      end else begin
         case (s1_mode_ff)
            OP_HALT: begin
               ex_status = ST_HALT;
               ex_halt   = 1'b1;
            end
            OP_LOAD: begin
               ex_wr_reg = 1'b1;
               ex_value  = REG_WIDTH'(mem_rd_ff);
            end
            OP_STORE: begin
               ex_wr_mem = 1'b1;
               ex_byte   = src_b[7:0];
            end
            OP_MOVE: begin
               ex_wr_reg = 1'b1;
               ex_value  = src_b;
            end
            OP_PUTI: begin
               ex_wr_reg = 1'b1;
               ex_value  = REG_WIDTH'(s1_op2_ff);
            end
            OP_ADD: begin
               ex_wr_reg = 1'b1;
               ex_value  = src_b + src_c;
            end
            OP_SUB: begin
               ex_wr_reg = 1'b1;
               ex_value  = src_b - src_c;
            end
            default: begin
               ex_status = ST_ILLEGAL;
            end
         endcase
      end
      rf_wr.en   = s1_adv && ex_wr_reg;
      rf_wr.addr = s1_op1_ff[REG_IDX_W-1:0];
      rf_wr.data = ex_value;
      ex_word = {4'b0000,
                 ex_byte,
                 ex_wr_mem ? 8'(ex_maddr) : 8'h00,
                 ex_wr_mem,
                 ex_value[31:0],
                 ex_wr_reg ? 8'(rf_wr.addr) : 8'h00,
                 ex_wr_reg,
                 ex_status};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   `BVM_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `BVM_ASSERT_SAME(a_no_reg_wr_halted, clock, reset, halted_ff, !rf_wr.en)
   `BVM_ASSERT_SAME(a_wr_only_on_adv, clock, reset, rf_wr.en || ex_wr_mem && s1_adv, s1_vld_ff)
   `BVM_ASSERT_NEXT(a_ignored_after_halt, clock, reset, s1_adv && halted_ff, rsp_tvalid && rsp_tdata[1:0] == ST_IGNORED)

endmodule

`default_nettype wire
